// ----- design/sds_pkg.sv -----
// Shared constants and types for the strongest-first sighting table.
package sds_pkg;

  localparam int TABLE_DEPTH  = 16;
  localparam int IDX_W        = $clog2(TABLE_DEPTH);
  localparam int RESULT_LIMIT = 16;
  localparam int ADDR_W       = 48;
  localparam int STR_W        = 8;
  localparam int RANK_W       = 4;
  localparam int OP_W         = 2;
  localparam int OUT_CNT_W    = 5;

  // live-entry tally carried by a drain probe, saturating at "two or more"
  localparam logic [1:0] LIVE_NONE = 2'd0;
  localparam logic [1:0] LIVE_ONE  = 2'd1;
  localparam logic [1:0] LIVE_MANY = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_RECORD = 2'd1,
    OP_DRAIN  = 2'd2
  } op_t;

  // item walking down the cell row
  typedef struct packed {
    logic                    valid;
    logic                    drain;  // 0: record lookup/append, 1: strongest search
    logic                    found;
    logic [1:0]              live;
    logic [IDX_W-1:0]        idx;
    logic [ADDR_W-1:0]       addr;
    logic signed [STR_W-1:0] str;
  } probe_t;

  // commands broadcast to every cell
  typedef struct packed {
    logic             clear;
    logic             consume;
    logic [IDX_W-1:0] idx;
  } bcast_t;

endpackage

// ----- design/sds_if.sv -----
// Valid/ready channel interfaces: input items, result items, configuration writes.
interface sds_in_if;
  logic                             valid;
  logic                             ready;
  logic [sds_pkg::OP_W-1:0]         operation;
  logic [sds_pkg::ADDR_W-1:0]       device_address;
  logic signed [sds_pkg::STR_W-1:0] signal_strength;

  modport source (output valid, operation, device_address, signal_strength, input ready);
  modport sink   (input valid, operation, device_address, signal_strength, output ready);
endinterface

interface sds_out_if;
  logic                             valid;
  logic                             ready;
  logic                             valid_res;
  logic [sds_pkg::ADDR_W-1:0]       out_address;
  logic signed [sds_pkg::STR_W-1:0] out_strength;
  logic [sds_pkg::RANK_W-1:0]       rank;
  logic                             last;

  modport source (output valid, valid_res, out_address, out_strength, rank, last,
                  input ready);
  modport sink   (input valid, valid_res, out_address, out_strength, rank, last,
                  output ready);
endinterface

interface sds_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [sds_pkg::OUT_CNT_W-1:0]     data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- design/sds_cell.sv -----
// One table slot: holds an entry and updates the probe passing through it.
module sds_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [sds_pkg::IDX_W-1:0]    cell_idx,
  input  sds_pkg::bcast_t              bcast,
  input  sds_pkg::probe_t              probe_in,
  output sds_pkg::probe_t              probe_out
);
  import sds_pkg::*;

  logic                    used_r, used_nxt;
  logic                    cons_r, cons_nxt;
  logic [ADDR_W-1:0]       addr_r, addr_nxt;
  logic signed [STR_W-1:0] str_r, str_nxt;
  probe_t                  probe_r, probe_nxt;
  logic                    live;

  assign live = used_r && !cons_r;

  // slot update and probe forwarding
  always_comb begin
    used_nxt  = used_r;
    cons_nxt  = cons_r;
    addr_nxt  = addr_r;
    str_nxt   = str_r;
    probe_nxt = probe_in;
    if (probe_in.valid) begin
      if (!probe_in.drain) begin
        if (live && addr_r == probe_in.addr && !probe_in.found) begin
          // live match: keep the stronger sighting
          probe_nxt.found = 1'b1;
          if (probe_in.str > str_r) begin
            str_nxt = probe_in.str;
          end
        end else if (!used_r && !probe_in.found) begin
          // first free slot, nothing matched above: append
          probe_nxt.found = 1'b1;
          used_nxt        = 1'b1;
          cons_nxt        = 1'b0;
          addr_nxt        = probe_in.addr;
          str_nxt         = probe_in.str;
        end
      end else if (live) begin
        if (probe_in.live != LIVE_MANY) begin
          probe_nxt.live = probe_in.live + LIVE_ONE;
        end
        // strictly stronger wins, so ties stay with the lower slot
        if (!probe_in.found || str_r > probe_in.str) begin
          probe_nxt.found = 1'b1;
          probe_nxt.idx   = cell_idx;
          probe_nxt.addr  = addr_r;
          probe_nxt.str   = str_r;
        end
      end
    end
    if (bcast.clear) begin
      used_nxt = 1'b0;
      cons_nxt = 1'b0;
    end
    if (bcast.consume && bcast.idx == cell_idx) begin
      cons_nxt = 1'b1;
    end
  end

  // control bits and probe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= 1'b0;
      cons_r  <= 1'b0;
      probe_r <= '0;
    end else begin
      used_r  <= used_nxt;
      cons_r  <= cons_nxt;
      probe_r <= probe_nxt;
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    str_r  <= str_nxt;
  end

  assign probe_out = probe_r;

endmodule

// ----- design/sighting_dedupe_strongest_first_top.sv -----
// Top level: sighting table as a row of cells plus the operation sequencer.
//
// Channels: in_ch takes items {operation, device_address, signal_strength};
// out_ch returns result items {valid_res, out_address, out_strength, rank,
// last}; cfg_ch writes max_out (always ready).
// Clear takes effect in the accepting cycle; the block is ready again at once.
// Record sends one probe down the 16-cell row; the next item can be taken
// once the probe has left the last cell.
// Drain runs one probe pass per result; each result is registered after its
// pass has left the last cell, and the next pass starts as it is loaded.
// The drain ends with the result marked last; an empty table gives one
// result with valid_res 0 and last 1.
// If the receiver stalls, the loaded result waits in the output register and
// the next result found waits until it is taken; new items are still accepted
// while the final result of a drain waits.
// Reset is synchronous: it empties the table (no live entries) and sets
// max_out to 16.
module sighting_dedupe_strongest_first_top (
  input logic   clk,
  input logic   rst_n,
  sds_in_if.sink    in_ch,
  sds_out_if.source out_ch,
  sds_cfg_if.sink   cfg_ch
);
  import sds_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_EMIT
  } state_t;

  state_t                  state_r;
  logic [OUT_CNT_W-1:0]    max_out_r;
  logic [OUT_CNT_W-1:0]    cnt_r;
  probe_t                  launch_r;
  probe_t                  win_r;
  logic                    out_valid_r;
  logic                    valid_res_r;
  logic [ADDR_W-1:0]       out_addr_r;
  logic signed [STR_W-1:0] out_str_r;
  logic [RANK_W-1:0]       rank_r;
  logic                    last_r;

  probe_t                  probe_w [0:TABLE_DEPTH];
  bcast_t                  bcast;
  logic                    in_acc;
  logic                    can_emit;
  logic                    final_res;
  logic                    launch_go;
  logic [OUT_CNT_W-1:0]    limit;
  logic [OUT_CNT_W-1:0]    cnt_inc;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;

  // effective drain limit: zero acts as one, saturate at the result limit
  always_comb begin
    if (max_out_r == '0) begin
      limit = OUT_CNT_W'(1);
    end else if (max_out_r > OUT_CNT_W'(RESULT_LIMIT)) begin
      limit = OUT_CNT_W'(RESULT_LIMIT);
    end else begin
      limit = max_out_r;
    end
  end

  assign cnt_inc   = cnt_r + OUT_CNT_W'(1);
  assign can_emit  = (state_r == S_EMIT) && (!out_valid_r || out_ch.ready);
  assign final_res = !win_r.found || (win_r.live != LIVE_MANY) || (cnt_inc >= limit);

  // a probe starts on a record or drain item, or for the next drain pass
  assign launch_go = (in_acc && (in_ch.operation == OP_RECORD ||
                                 in_ch.operation == OP_DRAIN)) ||
                     (can_emit && !final_res);

  // broadcast commands to the row
  always_comb begin
    bcast.clear   = in_acc && (in_ch.operation == OP_CLEAR);
    bcast.consume = can_emit && win_r.found;
    bcast.idx     = win_r.idx;
  end

  // cell row
  assign probe_w[0] = launch_r;
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    sds_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (IDX_W'(g)),
      .bcast     (bcast),
      .probe_in  (probe_w[g]),
      .probe_out (probe_w[g+1])
    );
  end

  // sequencer, probe launch and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      max_out_r      <= OUT_CNT_W'(RESULT_LIMIT);
      launch_r.valid <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      launch_r.valid <= launch_go;
      if (cfg_ch.valid) begin
        max_out_r <= cfg_ch.data;
      end
      // output register: load a new result or drop the one taken
      if (can_emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            launch_r.found <= 1'b0;
            launch_r.live  <= LIVE_NONE;
            launch_r.idx   <= '0;
            launch_r.addr  <= in_ch.device_address;
            launch_r.str   <= in_ch.signal_strength;
            cnt_r          <= '0;
            case (in_ch.operation)
              OP_RECORD: begin
                launch_r.drain <= 1'b0;
                state_r        <= S_RUN;
              end
              OP_DRAIN: begin
                launch_r.drain <= 1'b1;
                state_r        <= S_RUN;
              end
              default: begin
                state_r <= S_IDLE;
              end
            endcase
          end
        end
        S_RUN: begin
          // wait for the probe to leave the last cell
          if (probe_w[TABLE_DEPTH].valid) begin
            win_r   <= probe_w[TABLE_DEPTH];
            state_r <= probe_w[TABLE_DEPTH].drain ? S_EMIT : S_IDLE;
          end
        end
        S_EMIT: begin
          if (can_emit) begin
            last_r <= final_res;
            if (win_r.found) begin
              valid_res_r <= 1'b1;
              out_addr_r  <= win_r.addr;
              out_str_r   <= win_r.str;
              rank_r      <= cnt_r[RANK_W-1:0];
            end else begin
              valid_res_r <= 1'b0;
              out_addr_r  <= '0;
              out_str_r   <= '0;
              rank_r      <= '0;
            end
            if (final_res) begin
              state_r <= S_IDLE;
            end else begin
              // next strongest search, after the consume has landed
              cnt_r          <= cnt_inc;
              launch_r.drain <= 1'b1;
              launch_r.found <= 1'b0;
              launch_r.live  <= LIVE_NONE;
              state_r        <= S_RUN;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.valid_res    = valid_res_r;
  assign out_ch.out_address  = out_addr_r;
  assign out_ch.out_strength = out_str_r;
  assign out_ch.rank         = rank_r;
  assign out_ch.last         = last_r;

endmodule
